### design/twes_pkg.sv
// ----------------------------------------------------------------------------
// twes_pkg
// Shared codes, widths and control structs of the timing wheel scheduler.
// ----------------------------------------------------------------------------
package twes_pkg;

  // fixed field widths
  localparam int TICK_W      = 32;
  localparam int DELAY_W     = 6;
  localparam int SLOTS_REG_W = 7;
  localparam int BP_EN_W     = 4;
  localparam int NUM_BP      = 4;
  localparam int BP_IDX_W    = 2;
  localparam int IDLE_W      = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int FUNC_W      = 2;
  localparam int ERR_W       = 2;

  localparam logic [SLOTS_REG_W-1:0] SLOTS_RESET = 7'd16;
  localparam logic [IDLE_W-1:0]      IDLE_MAX    = 7'd127;

  // item functions
  localparam logic [FUNC_W-1:0] FUNC_SCHED  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PAUSE  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_RESUME = 2'd3;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_SLOT_FULL = 2'd1;
  localparam logic [ERR_W-1:0] ERR_DELAY     = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BP_EN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BP_TICK_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BP_TICK_D = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic set_flag;
    logic delay_err;
    logic mod_fast;
    logic div_init;
    logic div_step;
    logic fill_rd_slot;
    logic sched_commit;
    logic tick_eval;
    logic emit_entry;
  } twes_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic delay_big;
    logic fast_ok;
    logic div_last;
    logic tick_empty;
    logic emit_last;
  } twes_sts_t;

endpackage

### design/twes_ram.sv
// ----------------------------------------------------------------------------
// twes_ram
// Simple dual port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module twes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/twes_ctrl.sv
// ----------------------------------------------------------------------------
// twes_ctrl
// Sequencer for schedule, tick, pause and resume items.
// ----------------------------------------------------------------------------
module twes_ctrl
  import twes_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [FUNC_W-1:0] func_i,
  input  twes_sts_t         sts_i,
  output twes_cmd_t         cmd_o,
  output logic              busy_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MOD  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_SRD  = 3'd3;
  localparam logic [2:0] ST_SWR  = 3'd4;
  localparam logic [2:0] ST_TEVL = 3'd5;
  localparam logic [2:0] ST_EMIT = 3'd6;

  logic [2:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          unique case (func_i)
            FUNC_SCHED:  state_d = ST_MOD;
            FUNC_TICK:   state_d = ST_TEVL;
            FUNC_PAUSE,
            FUNC_RESUME: cmd_o.set_flag = 1'b1;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_MOD: begin
        priority if (sts_i.delay_big) begin
          cmd_o.delay_err = 1'b1;
          state_d         = ST_IDLE;
        end else if (sts_i.fast_ok) begin
          cmd_o.mod_fast = 1'b1;
          state_d        = ST_SRD;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_SRD;
        end
      end
      ST_SRD: begin
        cmd_o.fill_rd_slot = 1'b1;
        state_d            = ST_SWR;
      end
      ST_SWR: begin
        cmd_o.sched_commit = 1'b1;
        state_d            = ST_IDLE;
      end
      ST_TEVL: begin
        cmd_o.tick_eval = 1'b1;
        state_d         = sts_i.tick_empty ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit_entry = 1'b1;
        if (sts_i.emit_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

### design/twes_dp.sv
// ----------------------------------------------------------------------------
// twes_dp
// Datapath: wheel storage, slot reduction, tick bookkeeping and result register.
// ----------------------------------------------------------------------------
module twes_dp
  import twes_pkg::*;
#(
  parameter int WHEEL_SLOTS    = 64,
  parameter int SLOT_DEPTH     = 16,
  parameter int SOURCE_ID_BITS = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  twes_cmd_t                 cmd_i,
  output twes_sts_t                 sts_o,
  input  logic [FUNC_W-1:0]         func_i,
  input  logic [SOURCE_ID_BITS-1:0] source_id_i,
  input  logic [DELAY_W-1:0]        delay_i,
  input  logic                      external_work_i,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  output logic                      result_valid_o,
  output logic [SOURCE_ID_BITS-1:0] due_source_o,
  output logic                      due_valid_o,
  output logic                      last_o,
  output logic                      keep_running_o,
  output logic                      steady_state_o,
  output logic                      breakpoint_hit_o,
  output logic [ERR_W-1:0]          error_o,
  output logic [TICK_W-1:0]         tick_now_o
);

  localparam int PB  = $clog2(WHEEL_SLOTS);
  localparam int SB  = $clog2(WHEEL_SLOTS + (2 ** DELAY_W));
  localparam int CW  = SB + 1;
  localparam int CB  = $clog2(SB);
  localparam int FB  = $clog2(SLOT_DEPTH + 1);
  localparam int IB  = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int EAW = $clog2(WHEEL_SLOTS * SLOT_DEPTH);
  localparam logic [EAW-1:0] DEPTH_K = EAW'(SLOT_DEPTH);
  localparam logic [FB-1:0]  FILL_MAX = FB'(SLOT_DEPTH);

  // configuration registers
  logic [SLOTS_REG_W-1:0] slots_q;
  logic [BP_EN_W-1:0]     bp_en_q;
  logic [TICK_W-1:0]      bp_tick_q [NUM_BP];
  logic [BP_IDX_W-1:0]    bp_sel;

  // wheel state
  logic [TICK_W-1:0]      tick_q;
  logic [PB-1:0]          ptr_q;
  logic [IDLE_W-1:0]      idle_q;
  logic                   paused_q;
  logic [WHEEL_SLOTS-1:0] slot_vld_q;

  // item working registers
  logic [SOURCE_ID_BITS-1:0] id_q;
  logic [DELAY_W-1:0]        delay_q;
  logic                      ext_q;
  logic [SB-1:0]             sum_q;
  logic [PB-1:0]             slot_q;
  logic [CB-1:0]             cnt_q;
  logic [FB-1:0]             n_q;
  logic [IB-1:0]             idx_q;

  // memory ports
  logic [PB-1:0]             fill_raddr;
  logic [FB-1:0]             fill_rdata;
  logic                      fill_we;
  logic [FB-1:0]             fill_wdata;
  logic [EAW-1:0]            ent_raddr;
  logic [EAW-1:0]            ent_waddr;
  logic [SOURCE_ID_BITS-1:0] ent_rdata;
  logic                      ent_we;

  // combinational terms
  logic [CW-1:0]     w_c;
  logic [CW-1:0]     sum_c;
  logic [CW-1:0]     fast_c;
  logic [PB:0]       rem_sh;
  logic [CW-1:0]     rem_c;
  logic [PB-1:0]     rem_new;
  logic [FB-1:0]     fill_c;
  logic              full_c;
  logic [FB-1:0]     tfill_c;
  logic [FB-1:0]     n_c;
  logic              tick_active;
  logic [IDLE_W-1:0] idle_inc;
  logic [TICK_W-1:0] tick_inc;
  logic [CW-1:0]     ptr_nx;
  logic [PB-1:0]     ptr_inc;
  logic              steady_c;
  logic [NUM_BP-1:0] bp_match;
  logic              bp_c;
  logic              paused_new;
  logic [FB-1:0]     idx_inc;
  logic [IB-1:0]     rd_idx;
  logic [PB-1:0]     rd_slot;

  // slots in use clamped to one .. WHEEL_SLOTS
  always_comb begin
    priority if (slots_q == '0) begin
      w_c = CW'(1);
    end else if (CW'(slots_q) > CW'(WHEEL_SLOTS)) begin
      w_c = CW'(WHEEL_SLOTS);
    end else begin
      w_c = CW'(slots_q);
    end
  end

  // slot reduction, single subtract when the pointer is in range
  assign sum_c  = CW'(sum_q);
  assign fast_c = (sum_c >= w_c) ? (sum_c - w_c) : sum_c;

  // bit serial remainder step, slot_q holds the partial remainder
  assign rem_sh  = {slot_q, sum_q[cnt_q]};
  assign rem_c   = (CW'(rem_sh) >= w_c) ? (CW'(rem_sh) - w_c) : CW'(rem_sh);
  assign rem_new = PB'(rem_c);

  // fill count seen by a schedule item
  assign fill_c = slot_vld_q[slot_q] ? fill_rdata : '0;
  assign full_c = (fill_c >= FILL_MAX);

  // fill count seen by a tick item
  assign tfill_c = slot_vld_q[ptr_q] ? fill_rdata : '0;
  assign n_c     = (tfill_c > FILL_MAX) ? FILL_MAX : tfill_c;

  // tick bookkeeping
  assign tick_active = (n_c != '0) || ext_q;
  assign idle_inc = tick_active ? '0 : ((idle_q == IDLE_MAX) ? IDLE_MAX : idle_q + 1'b1);
  assign tick_inc = tick_q + 1'b1;
  assign ptr_nx   = CW'(ptr_q) + CW'(1);
  assign ptr_inc  = (ptr_nx >= w_c) ? '0 : PB'(ptr_nx);
  assign steady_c = (CW'(idle_inc) >= w_c);

  // breakpoint compare against the new tick
  always_comb begin
    for (int i = 0; i < NUM_BP; i++) begin
      bp_match[i] = bp_en_q[i] && (bp_tick_q[i] == tick_inc);
    end
  end
  assign bp_c       = !steady_c && (bp_match != '0);
  assign paused_new = paused_q || bp_c;

  // entry walk
  assign idx_inc = FB'(idx_q) + FB'(1);
  assign rd_idx  = (idx_inc < n_q) ? IB'(idx_inc) : idx_q;
  assign rd_slot = cmd_i.tick_eval ? ptr_q : slot_q;

  // memory addressing
  assign fill_raddr = cmd_i.fill_rd_slot ? slot_q : ptr_q;
  assign ent_raddr  = EAW'(rd_slot) * DEPTH_K + (cmd_i.tick_eval ? '0 : EAW'(rd_idx));
  assign ent_waddr  = EAW'(slot_q) * DEPTH_K + EAW'(fill_c[IB-1:0]);
  assign ent_we     = cmd_i.sched_commit && !full_c;
  assign fill_we    = ent_we;
  assign fill_wdata = fill_c + 1'b1;

  // status to the controller
  assign sts_o.delay_big  = (CW'(delay_q) >= w_c);
  assign sts_o.fast_ok    = (CW'(ptr_q) < w_c);
  assign sts_o.div_last   = (cnt_q == '0);
  assign sts_o.tick_empty = (n_c == '0);
  assign sts_o.emit_last  = (idx_inc == n_q);

  // fill count memory
  twes_ram #(
    .WIDTH(FB),
    .DEPTH(WHEEL_SLOTS)
  ) u_fill_ram (
    .clk_i  (clk_i),
    .we_i   (fill_we),
    .waddr_i(slot_q),
    .wdata_i(fill_wdata),
    .raddr_i(fill_raddr),
    .rdata_o(fill_rdata)
  );

  // slot entry memory
  twes_ram #(
    .WIDTH(SOURCE_ID_BITS),
    .DEPTH(WHEEL_SLOTS * SLOT_DEPTH)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ent_we),
    .waddr_i(ent_waddr),
    .wdata_i(id_q),
    .raddr_i(ent_raddr),
    .rdata_o(ent_rdata)
  );

  assign bp_sel = BP_IDX_W'(cfg_index_i - CFG_BP_TICK_A);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= SLOTS_RESET;
      bp_en_q <= '0;
      for (int i = 0; i < NUM_BP; i++) begin
        bp_tick_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      priority if (cfg_index_i == CFG_SLOTS) begin
        slots_q <= cfg_data_i[SLOTS_REG_W-1:0];
      end else if (cfg_index_i == CFG_BP_EN) begin
        bp_en_q <= cfg_data_i[BP_EN_W-1:0];
      end else if (cfg_index_i >= CFG_BP_TICK_A && cfg_index_i <= CFG_BP_TICK_D) begin
        bp_tick_q[bp_sel] <= cfg_data_i[TICK_W-1:0];
      end else begin
        slots_q <= slots_q;
      end
    end
  end

  // wheel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q     <= '0;
      ptr_q      <= '0;
      idle_q     <= '0;
      paused_q   <= 1'b1;
      slot_vld_q <= '0;
    end else begin
      if (cmd_i.set_flag) begin
        paused_q <= (func_i == FUNC_PAUSE);
      end
      if (ent_we) begin
        slot_vld_q[slot_q] <= 1'b1;
      end
      if (cmd_i.tick_eval) begin
        slot_vld_q[ptr_q] <= 1'b0;
        paused_q          <= paused_new;
        tick_q            <= steady_c ? '0 : tick_inc;
        idle_q            <= steady_c ? '0 : idle_inc;
        ptr_q             <= steady_c ? '0 : ptr_inc;
      end
    end
  end

  // item working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      id_q    <= source_id_i;
      delay_q <= delay_i;
      ext_q   <= external_work_i;
      sum_q   <= SB'(ptr_q) + SB'(delay_i);
    end
    priority if (cmd_i.mod_fast) begin
      slot_q <= PB'(fast_c);
    end else if (cmd_i.div_init) begin
      slot_q <= '0;
      cnt_q  <= CB'(SB - 1);
    end else if (cmd_i.div_step) begin
      slot_q <= rem_new;
      cnt_q  <= cnt_q - 1'b1;
    end else if (cmd_i.tick_eval) begin
      slot_q <= ptr_q;
      n_q    <= n_c;
      idx_q  <= '0;
    end else if (cmd_i.emit_entry) begin
      idx_q <= IB'(idx_inc);
    end else begin
      cnt_q <= cnt_q;
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= cmd_i.set_flag || cmd_i.delay_err || cmd_i.sched_commit ||
                        (cmd_i.tick_eval && (n_c == '0)) || cmd_i.emit_entry;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    priority if (cmd_i.set_flag) begin
      due_source_o     <= '0;
      due_valid_o      <= 1'b0;
      last_o           <= 1'b1;
      keep_running_o   <= (func_i != FUNC_PAUSE);
      steady_state_o   <= 1'b0;
      breakpoint_hit_o <= 1'b0;
      error_o          <= ERR_NONE;
      tick_now_o       <= tick_q;
    end else if (cmd_i.delay_err || cmd_i.sched_commit) begin
      due_source_o     <= '0;
      due_valid_o      <= 1'b0;
      last_o           <= 1'b1;
      keep_running_o   <= !paused_q;
      steady_state_o   <= 1'b0;
      breakpoint_hit_o <= 1'b0;
      error_o          <= cmd_i.delay_err ? ERR_DELAY : (full_c ? ERR_SLOT_FULL : ERR_NONE);
      tick_now_o       <= tick_q;
    end else if (cmd_i.tick_eval) begin
      due_source_o     <= '0;
      due_valid_o      <= 1'b0;
      last_o           <= 1'b1;
      keep_running_o   <= !(steady_c || paused_new);
      steady_state_o   <= steady_c;
      breakpoint_hit_o <= bp_c;
      error_o          <= ERR_NONE;
      tick_now_o       <= steady_c ? '0 : tick_inc;
    end else if (cmd_i.emit_entry) begin
      due_source_o <= ent_rdata;
      due_valid_o  <= 1'b1;
      last_o       <= (idx_inc == n_q);
    end else begin
      due_valid_o <= due_valid_o;
    end
  end

endmodule

### design/timing_wheel_event_scheduler.sv
// ----------------------------------------------------------------------------
// timing_wheel_event_scheduler
// Hashed timing wheel: schedules source ids into slots and fires them on ticks.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start_i is high and busy_o is low. func_i selects
//   schedule, tick, pause or resume. Each result is shown for one cycle with
//   result_valid_o high; last_o marks the final result of an item. The
//   receiver cannot stall, so results are never held.
//   Registers are written on the cfg channel (cfg_ready_o is always high); the user
//   must write them only while the block is idle, the block does not enforce it.
// Timing:
//   pause and resume: result in the cycle after the item is taken, no busy time.
//   schedule: check, fill count read, then write; an item whose delay is
//   too large ends after the check. When the slot pointer sits beyond the
//   slots in use, the slot is found by a bit serial remainder unit before the fill count read.
//   tick: fill count read and update, then one result per
//   cycle as due entries stream out of the entry memory.
// Reset:
//   all slots empty, tick and pointer zero, paused, 16 slots in use.
// ----------------------------------------------------------------------------
module timing_wheel_event_scheduler
  import twes_pkg::*;
#(
  parameter int WHEEL_SLOTS    = 64,
  parameter int SLOT_DEPTH     = 16,
  parameter int SOURCE_ID_BITS = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [FUNC_W-1:0]         func_i,
  input  logic [SOURCE_ID_BITS-1:0] source_id_i,
  input  logic [DELAY_W-1:0]        delay_i,
  input  logic                      external_work_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  output logic                      result_valid_o,
  output logic [SOURCE_ID_BITS-1:0] due_source_o,
  output logic                      due_valid_o,
  output logic                      last_o,
  output logic                      keep_running_o,
  output logic                      steady_state_o,
  output logic                      breakpoint_hit_o,
  output logic [ERR_W-1:0]          error_o,
  output logic [TICK_W-1:0]         tick_now_o
);

  twes_cmd_t cmd;
  twes_sts_t sts;

  assign cfg_ready_o = 1'b1;

  // sequencer
  twes_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .func_i (func_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  // datapath
  twes_dp #(
    .WHEEL_SLOTS   (WHEEL_SLOTS),
    .SLOT_DEPTH    (SLOT_DEPTH),
    .SOURCE_ID_BITS(SOURCE_ID_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .func_i          (func_i),
    .source_id_i     (source_id_i),
    .delay_i         (delay_i),
    .external_work_i (external_work_i),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .result_valid_o  (result_valid_o),
    .due_source_o    (due_source_o),
    .due_valid_o     (due_valid_o),
    .last_o          (last_o),
    .keep_running_o  (keep_running_o),
    .steady_state_o  (steady_state_o),
    .breakpoint_hit_o(breakpoint_hit_o),
    .error_o         (error_o),
    .tick_now_o      (tick_now_o)
  );

endmodule

### bench/timing_wheel_event_scheduler_tb.sv
// ----------------------------------------------------------------------------
// timing_wheel_event_scheduler_tb
// Self-checking bench for the timing wheel scheduler. A behavioral copy of
// the wheel predicts every due source and status word. Each result strobe is
// compared field by field with the oldest pending prediction. Directed items
// cover the edge cases, then random phases run under several wheel sizes
// and breakpoint setups, with random gaps on the command side.
// ----------------------------------------------------------------------------
module timing_wheel_event_scheduler_tb;
  import twes_pkg::*;

  localparam int WHEEL_SLOTS  = 64;
  localparam int SLOT_DEPTH   = 16;
  localparam int ID_W         = 10;
  localparam int QUIET_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 28;

  // indexes past the last breakpoint register, ignored by the block
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_BP_TICK_D + 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_BP_TICK_D + 3'd2;

  typedef struct packed {
    logic [ID_W-1:0]   source;
    logic              fired;
    logic              last;
    logic              run;
    logic              steady;
    logic              bp;
    logic [ERR_W-1:0]  err;
    logic [TICK_W-1:0] tick;
  } due_rec_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  logic [FUNC_W-1:0]     func_i = FUNC_SCHED;
  logic [ID_W-1:0]       source_id_i = '0;
  logic [DELAY_W-1:0]    delay_i = '0;
  logic                  external_work_i = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_SLOTS;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  result_valid_o;
  logic [ID_W-1:0]       due_source_o;
  logic                  due_valid_o;
  logic                  last_o;
  logic                  keep_running_o;
  logic                  steady_state_o;
  logic                  breakpoint_hit_o;
  logic [ERR_W-1:0]      error_o;
  logic [TICK_W-1:0]     tick_now_o;

  timing_wheel_event_scheduler #(
    .WHEEL_SLOTS   (WHEEL_SLOTS),
    .SLOT_DEPTH    (SLOT_DEPTH),
    .SOURCE_ID_BITS(ID_W)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .func_i          (func_i),
    .source_id_i     (source_id_i),
    .delay_i         (delay_i),
    .external_work_i (external_work_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .result_valid_o  (result_valid_o),
    .due_source_o    (due_source_o),
    .due_valid_o     (due_valid_o),
    .last_o          (last_o),
    .keep_running_o  (keep_running_o),
    .steady_state_o  (steady_state_o),
    .breakpoint_hit_o(breakpoint_hit_o),
    .error_o         (error_o),
    .tick_now_o      (tick_now_o)
  );

  always #5 clk_i = ~clk_i;

  // wheel state mirror
  logic [ID_W-1:0]        slot_ids [WHEEL_SLOTS][SLOT_DEPTH];
  int unsigned            fill_cnt [WHEEL_SLOTS];
  logic [TICK_W-1:0]      wheel_tick;
  int unsigned            wheel_ptr;
  int unsigned            idle_run;
  bit                     paused_m;
  logic [SLOTS_REG_W-1:0] slots_reg;
  logic [BP_EN_W-1:0]     bp_enable;
  logic [TICK_W-1:0]      bp_tick [NUM_BP];

  due_rec_t    due_q[$];
  due_rec_t    got_rec;
  due_rec_t    want_rec;
  int unsigned faults;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned steady_count;
  int unsigned bp_count;
  int unsigned full_drops;
  int unsigned delay_drops;
  int unsigned phases_run;
  int unsigned cycles;
  bit          tight_run;

  // effective wheel size after clamping
  function automatic int unsigned slots_eff();
    if (slots_reg == '0) return 1;
    if (slots_reg > WHEEL_SLOTS) return WHEEL_SLOTS;
    return 32'(slots_reg);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (tight_run || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // predict the results of one accepted item and queue them
  task automatic wheel_step(input logic [FUNC_W-1:0] func, input logic [ID_W-1:0] id,
                            input logic [DELAY_W-1:0] dly, input logic ext);
    int unsigned w;
    int unsigned slot;
    int unsigned n;
    due_rec_t    rec;
    w = slots_eff();
    rec = '0;
    rec.last = 1'b1;
    case (func)
      FUNC_SCHED: begin
        rec.err = ERR_NONE;
        if (dly >= w) begin
          rec.err = ERR_DELAY;
          delay_drops++;
        end else begin
          slot = (wheel_ptr + dly) % w;
          if (fill_cnt[slot] >= SLOT_DEPTH) begin
            rec.err = ERR_SLOT_FULL;
            full_drops++;
          end else begin
            slot_ids[slot][fill_cnt[slot]] = id;
            fill_cnt[slot]++;
          end
        end
        rec.run = !paused_m;
        rec.tick = wheel_tick;
        due_q.push_back(rec);
      end
      FUNC_PAUSE, FUNC_RESUME: begin
        paused_m = (func == FUNC_PAUSE);
        rec.run = !paused_m;
        rec.tick = wheel_tick;
        due_q.push_back(rec);
      end
      default: begin
        slot = wheel_ptr;
        n = fill_cnt[slot];
        fill_cnt[slot] = 0;
        if (n > 0 || ext) idle_run = 0;
        else if (idle_run < IDLE_MAX) idle_run++;
        wheel_tick++;
        wheel_ptr = (slot + 1 >= w) ? 0 : slot + 1;
        if (idle_run >= w) begin
          // steady state clears the counters and skips the breakpoints
          rec.steady = 1'b1;
          wheel_tick = '0;
          idle_run = 0;
          wheel_ptr = 0;
          steady_count++;
        end else begin
          for (int i = 0; i < NUM_BP; i++) begin
            if (!rec.bp && bp_enable[i] && bp_tick[i] == wheel_tick) begin
              rec.bp = 1'b1;
              paused_m = 1'b1;
            end
          end
          if (rec.bp) bp_count++;
        end
        rec.run = !(rec.steady || paused_m);
        rec.tick = wheel_tick;
        if (n == 0) begin
          due_q.push_back(rec);
        end else begin
          rec.fired = 1'b1;
          for (int i = 0; i < n; i++) begin
            rec.source = slot_ids[slot][i];
            rec.last = (i == n - 1);
            due_q.push_back(rec);
          end
        end
      end
    endcase
  endtask

  // drive one item, wait for it to be taken, then predict it
  task automatic send_item(input logic [FUNC_W-1:0] func, input logic [ID_W-1:0] id,
                           input logic [DELAY_W-1:0] dly, input logic ext);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      @(negedge clk_i);
      start_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i = 1'b1;
    func_i = func;
    source_id_i = id;
    delay_i = dly;
    external_work_i = ext;
    do @(posedge clk_i); while (busy_o);
    wheel_step(func, id, dly, ext);
    items_sent++;
  endtask

  // let every pending result come out, then some margin
  task automatic wait_quiet();
    @(negedge clk_i);
    start_i = 1'b0;
    while (due_q.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_SLOTS) slots_reg = data[SLOTS_REG_W-1:0];
    else if (idx == CFG_BP_EN) bp_enable = data[BP_EN_W-1:0];
    else if (idx >= CFG_BP_TICK_A && idx <= CFG_BP_TICK_D) bp_tick[idx - CFG_BP_TICK_A] = data;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // wheel size with junk in the unused upper bits
  task automatic set_wheel(input logic [SLOTS_REG_W-1:0] slots_val);
    logic [CFG_DATA_W-1:0] data;
    data = $urandom();
    data[SLOTS_REG_W-1:0] = slots_val;
    write_reg(CFG_SLOTS, data);
  endtask

  task automatic set_enable(input logic [BP_EN_W-1:0] en);
    logic [CFG_DATA_W-1:0] data;
    data = $urandom();
    data[BP_EN_W-1:0] = en;
    write_reg(CFG_BP_EN, data);
  endtask

  // every opcode, delay extremes, empty tick and tick while paused
  task automatic test_basic_ops();
    send_item(FUNC_RESUME, ID_W'($urandom()), DELAY_W'($urandom()), 1'b0);
    send_item(FUNC_SCHED, 10'h3FF, 6'd0, 1'b1);
    send_item(FUNC_SCHED, 10'h155, 6'd15, 1'b0);
    send_item(FUNC_SCHED, 10'h2AA, 6'd16, 1'b0);
    send_item(FUNC_SCHED, 10'h0F0, 6'h3F, 1'b1);
    send_item(FUNC_TICK, ID_W'($urandom()), DELAY_W'($urandom()), 1'b0);
    send_item(FUNC_TICK, ID_W'($urandom()), DELAY_W'($urandom()), 1'b1);
    send_item(FUNC_PAUSE, ID_W'($urandom()), DELAY_W'($urandom()), 1'b0);
    send_item(FUNC_TICK, ID_W'($urandom()), DELAY_W'($urandom()), 1'b0);
  endtask

  // size zero acts as one slot: fill it past capacity, drain it, go steady
  task automatic test_slot_full();
    wait_quiet();
    set_wheel('0);
    for (int i = 0; i <= SLOT_DEPTH; i++)
      send_item(FUNC_SCHED, ID_W'(i * 60), 6'd0, 1'b0);
    send_item(FUNC_TICK, ID_W'($urandom()), DELAY_W'($urandom()), 1'b0);
    send_item(FUNC_TICK, ID_W'($urandom()), DELAY_W'($urandom()), 1'b0);
  endtask

  // two enabled breakpoints a few ticks ahead, the others at extremes
  task automatic test_breakpoints();
    wait_quiet();
    set_wheel(7'd64);
    write_reg(CFG_BP_TICK_A, wheel_tick + 2);
    write_reg(CFG_BP_TICK_A + 3'd1, '1);
    write_reg(CFG_BP_TICK_A + 3'd2, wheel_tick + 3);
    write_reg(CFG_BP_TICK_D, '0);
    write_reg(CFG_SPARE_LO, $urandom());
    write_reg(CFG_SPARE_HI, $urandom());
    set_enable(4'b0101);
    send_item(FUNC_RESUME, ID_W'($urandom()), DELAY_W'($urandom()), 1'b0);
    send_item(FUNC_TICK, ID_W'($urandom()), DELAY_W'($urandom()), 1'b1);
    send_item(FUNC_TICK, ID_W'($urandom()), DELAY_W'($urandom()), 1'b1);
    send_item(FUNC_RESUME, ID_W'($urandom()), DELAY_W'($urandom()), 1'b0);
    send_item(FUNC_TICK, ID_W'($urandom()), DELAY_W'($urandom()), 1'b0);
  endtask

  // one random phase under a given wheel size and breakpoint mask
  task automatic run_phase(input logic [SLOTS_REG_W-1:0] slots_val, input logic [BP_EN_W-1:0] en);
    int unsigned w;
    int unsigned r;
    int unsigned k;
    logic [TICK_W-1:0] bp_val;
    wait_quiet();
    set_wheel(slots_val);
    for (int i = 0; i < NUM_BP; i++) begin
      r = $urandom_range(0, 9);
      if (r < 6) bp_val = wheel_tick + $urandom_range(1, 12);
      else if (r < 7) bp_val = '0;
      else if (r < 8) bp_val = '1;
      else bp_val = $urandom();
      write_reg(CFG_BP_TICK_A + CFG_IDX_W'(i), bp_val);
    end
    set_enable(en);
    tight_run = ($urandom_range(0, 3) == 0);
    phases_run++;
    w = slots_eff();
    k = 0;
    while (k < PHASE_ITEMS) begin
      r = $urandom_range(0, 99);
      if (w <= 8 && r < 8) begin
        // run of ticks without external work, long enough to reach steady state once the slots are empty
        for (int i = 0; i <= w; i++)
          send_item(FUNC_TICK, ID_W'($urandom()), DELAY_W'($urandom()), 1'b0);
        k += w + 1;
      end else if (r < 52) begin
        send_item(FUNC_SCHED, ID_W'($urandom()),
                  ($urandom_range(0, 9) == 0) ? DELAY_W'($urandom_range(0, 63)) :
                                                DELAY_W'($urandom_range(0, w - 1)),
                  1'($urandom_range(0, 1)));
        k++;
      end else if (r < 86) begin
        send_item(FUNC_TICK, ID_W'($urandom()), DELAY_W'($urandom()),
                  $urandom_range(0, 3) == 0);
        k++;
      end else if (r < 95) begin
        send_item(FUNC_RESUME, ID_W'($urandom()), DELAY_W'($urandom()),
                  1'($urandom_range(0, 1)));
        k++;
      end else begin
        send_item(FUNC_PAUSE, ID_W'($urandom()), DELAY_W'($urandom()),
                  1'($urandom_range(0, 1)));
        k++;
      end
    end
  endtask

  // sizes chosen so a large wheel is followed by a small one, leaving the
  // pointer past the end of the wheel
  task automatic test_random_phases();
    run_phase(7'd16, 4'hF);
    run_phase(7'd0, 4'h3);
    run_phase(7'd64, 4'hA);
    run_phase(7'd5, 4'h0);
    run_phase(7'd127, 4'hF);
    run_phase(7'd2, 4'h5);
    run_phase(7'd1, 4'hC);
    run_phase(7'd33, BP_EN_W'($urandom()));
  endtask

  task automatic note_fault(input string what, input due_rec_t want, input due_rec_t got);
    faults++;
    if (faults <= 10)
      $display({"%s: expected src=%0d fired=%0b last=%0b run=%0b steady=%0b bp=%0b ",
                "err=%0d tick=%0d, got src=%0d fired=%0b last=%0b run=%0b steady=%0b ",
                "bp=%0b err=%0d tick=%0d"},
               what, want.source, want.fired, want.last, want.run, want.steady, want.bp,
               want.err, want.tick, got.source, got.fired, got.last, got.run, got.steady,
               got.bp, got.err, got.tick);
  endtask

  // compare each result strobe with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      got_rec.source = due_source_o;
      got_rec.fired = due_valid_o;
      got_rec.last = last_o;
      got_rec.run = keep_running_o;
      got_rec.steady = steady_state_o;
      got_rec.bp = breakpoint_hit_o;
      got_rec.err = error_o;
      got_rec.tick = tick_now_o;
      results_seen++;
      if (due_q.size() == 0) begin
        note_fault("unexpected result", '0, got_rec);
      end else begin
        want_rec = due_q.pop_front();
        if (got_rec.source !== want_rec.source || got_rec.fired !== want_rec.fired ||
            got_rec.last !== want_rec.last || got_rec.run !== want_rec.run ||
            got_rec.steady !== want_rec.steady || got_rec.bp !== want_rec.bp ||
            got_rec.err !== want_rec.err || got_rec.tick !== want_rec.tick)
          note_fault("result mismatch", want_rec, got_rec);
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, due_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    faults = 0;
    items_sent = 0;
    results_seen = 0;
    steady_count = 0;
    bp_count = 0;
    full_drops = 0;
    delay_drops = 0;
    phases_run = 0;
    cycles = 0;
    tight_run = 1'b0;
    for (int s = 0; s < WHEEL_SLOTS; s++) fill_cnt[s] = 0;
    wheel_tick = '0;
    wheel_ptr = 0;
    idle_run = 0;
    paused_m = 1'b1;
    slots_reg = SLOTS_RESET;
    bp_enable = '0;
    for (int i = 0; i < NUM_BP; i++) bp_tick[i] = '0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_basic_ops();
    test_slot_full();
    test_breakpoints();
    test_random_phases();
    wait_quiet();

    if (due_q.size() != 0) note_fault("missing result", due_q[0], '0);
    $display("ran %0d items in %0d random phases, %0d results checked", items_sent,
             phases_run, results_seen);
    $display("seen %0d steady-state ticks, %0d breakpoint stops, %0d full-slot and %0d delay drops",
             steady_count, bp_count, full_drops, delay_drops);
    if (faults == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", faults);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### timing_wheel_event_scheduler.f
design/twes_pkg.sv
design/twes_ram.sv
design/twes_ctrl.sv
design/twes_dp.sv
design/timing_wheel_event_scheduler.sv
bench/timing_wheel_event_scheduler_tb.sv
